// ===== design/cfcc_pkg.sv =====
// Package for the command frame CRC check and node match block.
// Holds frame layout constants, CRC constants, status and command codes,
// the channel payload types and the bit-serial CRC step. No dependencies.
package cfcc_pkg;

    // Frame layout
    localparam int CHECKED_BYTES  = 15;
    localparam int FRAME_LEN      = CHECKED_BYTES + 2;
    localparam int EUI_BYTES      = 8;
    localparam int CMD_FIRST      = 8;
    localparam int CMD_BYTES      = 6;
    localparam int POS_W          = 5;
    localparam int NODE_COUNT_DEF = 16;

    // CRC-16 constants, MSB first
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h8005;

    // Input command codes
    localparam logic CMD_FRAME_BYTE  = 1'b0;
    localparam logic CMD_TABLE_WRITE = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_CRC_BAD  = 2'd0;
    localparam logic [1:0] STATUS_NO_MATCH = 2'd1;
    localparam logic [1:0] STATUS_MATCH    = 2'd2;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  data_byte;
        logic [3:0]  entry_index;
        logic [63:0] entry_eui;
    } cfcc_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] node_index;
        logic [7:0] write_flag;
        logic [7:0] unit_state;
        logic [7:0] unit_mode;
        logic [7:0] fan_level;
        logic [7:0] temp_setpoint;
        logic [7:0] read_flag;
    } cfcc_out_t;

    // One bit of the CRC division: shift left, fold in the polynomial
    // when the top bit falls out.
    function automatic logic [15:0] crc_shift(input logic [15:0] crc);
        logic [15:0] shifted;
        shifted = {crc[14:0], 1'b0};
        return crc[15] ? (shifted ^ CRC_POLY) : shifted;
    endfunction

endpackage

// ===== design/cfcc_if.sv =====
// Valid/ready channel interfaces for frame bytes in and results out.
// Depends on cfcc_pkg for the payload types.
interface cfcc_in_if;
    import cfcc_pkg::*;
    logic     valid;
    logic     ready;
    cfcc_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cfcc_out_if;
    import cfcc_pkg::*;
    logic      valid;
    logic      ready;
    cfcc_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/cfcc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cfcc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/command_frame_crc_check_and_match.sv =====
// Command frame CRC check and node match. A checked frame byte (0..14) is
// accepted and then folded into the CRC by the bit-serial CRC loop. Byte 15 is
// only captured; after byte 16 the result goes straight to the finish step on a
// CRC mismatch, otherwise after the serial table search. Reset is asynchronous,
// active low; table entries read as zero until written, through per-entry valid
// flags.
module command_frame_crc_check_and_match #(
    parameter int NODE_COUNT = cfcc_pkg::NODE_COUNT_DEF
) (
    input logic        clk,
    input logic        rst_n,
    cfcc_in_if.sink    frame_in,
    cfcc_out_if.source result_out
);
    import cfcc_pkg::*;

    localparam int IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODE_COUNT - 1);

    // Sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CRC    = 2'd1;
    localparam logic [1:0] ST_SEARCH = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      crc_reg, crc_next;
    logic [2:0]       bit_cnt_reg, bit_cnt_next;
    logic [63:0]      eui_reg, eui_next;
    logic [7:0]       exp_hi_reg, exp_hi_next;
    logic [7:0]       cmd_val_reg [CMD_BYTES];
    logic [7:0]       cmd_val_next [CMD_BYTES];
    logic [IDX_W-1:0] search_addr_reg, search_addr_next;
    logic             check_reg, check_next;
    logic             check_last_reg, check_last_next;
    logic             check_ok_reg, check_ok_next;
    logic [IDX_W-1:0] check_addr_reg, check_addr_next;
    logic [1:0]       res_status_reg, res_status_next;
    logic [IDX_W-1:0] res_index_reg, res_index_next;
    logic             out_valid_reg, out_valid_next;
    cfcc_out_t        out_data_reg, out_data_next;
    logic [NODE_COUNT-1:0] entry_valid_reg;

    logic             in_fire;
    logic             tbl_wr;
    logic [IDX_W-1:0] tbl_wr_addr;
    logic             ram_rd_en;
    logic [63:0]      ram_rd_data;
    logic [63:0]      entry_eui;
    logic             entry_match;
    logic [2:0]       cmd_slot;

    assign frame_in.ready = (state_reg == ST_IDLE);
    assign in_fire        = frame_in.valid && frame_in.ready;

    // Table writes with an index beyond the table are dropped.
    assign tbl_wr = in_fire && (frame_in.data.cmd == CMD_TABLE_WRITE)
                    && ({5'd0, frame_in.data.entry_index} < 9'(NODE_COUNT));
    assign tbl_wr_addr = IDX_W'(frame_in.data.entry_index);
    assign ram_rd_en   = (state_reg == ST_SEARCH);

    cfcc_ram #(
        .WIDTH (64),
        .DEPTH (NODE_COUNT)
    ) u_eui_ram (
        .clk     (clk),
        .wr_en   (tbl_wr),
        .wr_addr (tbl_wr_addr),
        .wr_data (frame_in.data.entry_eui),
        .rd_en   (ram_rd_en),
        .rd_addr (search_addr_reg),
        .rd_data (ram_rd_data)
    );

    // The shared 64-bit comparator; entries never written read as zero.
    assign entry_eui   = check_ok_reg ? ram_rd_data : 64'd0;
    assign entry_match = (entry_eui == eui_reg);
    assign cmd_slot    = 3'(pos_reg - POS_W'(CMD_FIRST));

    // Sequencer and datapath next-state logic.
    always_comb
    begin
        state_next       = state_reg;
        pos_next         = pos_reg;
        crc_next         = crc_reg;
        bit_cnt_next     = bit_cnt_reg;
        eui_next         = eui_reg;
        exp_hi_next      = exp_hi_reg;
        cmd_val_next     = cmd_val_reg;
        search_addr_next = search_addr_reg;
        check_next       = 1'b0;
        check_last_next  = check_last_reg;
        check_ok_next    = check_ok_reg;
        check_addr_next  = check_addr_reg;
        res_status_next  = res_status_reg;
        res_index_next   = res_index_reg;
        out_valid_next   = out_valid_reg && !result_out.ready;
        out_data_next    = out_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (frame_in.data.cmd == CMD_FRAME_BYTE))
                begin
                    // Capture the frame fields by position.
                    if (pos_reg < POS_W'(EUI_BYTES))
                    begin
                        eui_next = {eui_reg[55:0], frame_in.data.data_byte};
                    end
                    else if (pos_reg < POS_W'(CMD_FIRST + CMD_BYTES))
                    begin
                        cmd_val_next[cmd_slot] = frame_in.data.data_byte;
                    end
                    else if (pos_reg == POS_W'(CHECKED_BYTES))
                    begin
                        exp_hi_next = frame_in.data.data_byte;
                    end

                    if (pos_reg < POS_W'(CHECKED_BYTES))
                    begin
                        crc_next     = crc_reg ^ {frame_in.data.data_byte, 8'h00};
                        bit_cnt_next = 3'd0;
                        state_next   = ST_CRC;
                    end

                    if (pos_reg == POS_W'(FRAME_LEN - 1))
                    begin
                        // Last byte: check the CRC, then restart the frame.
                        pos_next = '0;
                        crc_next = CRC_INIT;
                        if ({exp_hi_reg, frame_in.data.data_byte} != crc_reg)
                        begin
                            res_status_next = STATUS_CRC_BAD;
                            state_next      = ST_FINISH;
                        end
                        else
                        begin
                            search_addr_next = '0;
                            state_next       = ST_SEARCH;
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end

            ST_CRC:
            begin
                crc_next     = crc_shift(crc_reg);
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == 3'd7)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_SEARCH:
            begin
                // Issue one read per cycle; compare the previous one.
                check_next      = 1'b1;
                check_addr_next = search_addr_reg;
                check_last_next = (search_addr_reg == LAST_IDX);
                check_ok_next   = entry_valid_reg[search_addr_reg];
                if (search_addr_reg != LAST_IDX)
                begin
                    search_addr_next = search_addr_reg + 1'b1;
                end

                if (check_reg && entry_match)
                begin
                    res_status_next = STATUS_MATCH;
                    res_index_next  = check_addr_reg;
                    state_next      = ST_FINISH;
                end
                else if (check_reg && check_last_reg)
                begin
                    res_status_next = STATUS_NO_MATCH;
                    state_next      = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                // Load the output register once it is free.
                if (!out_valid_reg || result_out.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_data_next.status = res_status_reg;
                    if (res_status_reg == STATUS_MATCH)
                    begin
                        out_data_next.node_index    = 4'(res_index_reg);
                        out_data_next.write_flag    = cmd_val_reg[0];
                        out_data_next.unit_state    = cmd_val_reg[1];
                        out_data_next.unit_mode     = cmd_val_reg[2];
                        out_data_next.fan_level     = cmd_val_reg[3];
                        out_data_next.temp_setpoint = cmd_val_reg[4];
                        out_data_next.read_flag     = cmd_val_reg[5];
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            pos_reg         <= '0;
            crc_reg         <= CRC_INIT;
            eui_reg         <= '0;
            exp_hi_reg      <= '0;
            check_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
            entry_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            eui_reg       <= eui_next;
            exp_hi_reg    <= exp_hi_next;
            check_reg     <= check_next;
            out_valid_reg <= out_valid_next;
            if (tbl_wr)
            begin
                entry_valid_reg[tbl_wr_addr] <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        bit_cnt_reg     <= bit_cnt_next;
        cmd_val_reg     <= cmd_val_next;
        search_addr_reg <= search_addr_next;
        check_last_reg  <= check_last_next;
        check_ok_reg    <= check_ok_next;
        check_addr_reg  <= check_addr_next;
        res_status_reg  <= res_status_next;
        res_index_reg   <= res_index_next;
        out_data_reg    <= out_data_next;
    end

    assign result_out.valid = out_valid_reg;
    assign result_out.data  = out_data_reg;

    // A new result appears only when the sequencer hands it over.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_FINISH)
        else $error("result appeared outside the finish step");

    // The CRC loop runs exactly eight shifts per byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CRC) && (bit_cnt_reg == 3'd7) |=> state_reg == ST_IDLE)
        else $error("CRC loop did not end after eight shifts");

    // Only a match carries an index and command values.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_data_reg.status != STATUS_MATCH)
        |-> (out_data_reg.node_index == 4'd0) && (out_data_reg.write_flag == 8'd0)
            && (out_data_reg.read_flag == 8'd0))
        else $error("non-match result carries match fields");

    // The frame position never runs past the last byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < POS_W'(FRAME_LEN))
        else $error("frame position out of range");

endmodule

// ===== tb/frame_verdict_checker.sv =====
// Checker for command_frame_crc_check_and_match. It watches the frame and result
// channels, predicts the verdict of every frame and compares each result transfer.
// Depends on cfcc_pkg and the channel interfaces cfcc_in_if and cfcc_out_if.
module frame_verdict_checker #(
    parameter int NODE_COUNT = cfcc_pkg::NODE_COUNT_DEF
) (
    input  logic clk,
    input  logic rst_n,
    cfcc_in_if   frame_ch,
    cfcc_out_if  result_ch,
    output int   error_count,
    output int   pending_count,
    output int   crc_bad_count,
    output int   no_match_count,
    output int   match_count
);
    import cfcc_pkg::*;

    // Predicted block state.
    logic [POS_W-1:0] byte_pos;
    logic [15:0]      crc_acc;
    logic [63:0]      frame_eui;
    logic [7:0]       cmd_vals [CMD_BYTES];
    logic [7:0]       crc_hi;
    logic [63:0]      node_table [NODE_COUNT];
    cfcc_out_t        expected_verdicts [$];

    int mismatches    = 0;
    int crc_bad_seen  = 0;
    int no_match_seen = 0;
    int match_seen    = 0;

    // Fold one byte into the CRC-16, most significant bit first.
    function automatic logic [15:0] crc16_step(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        repeat (8)
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        return c;
    endfunction

    // Report one field that differs from its predicted value.
    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // Update the predicted state with one accepted input transfer and queue the
    // verdict when the transfer closes a frame.
    task automatic absorb_transfer(input cfcc_in_t item);
        cfcc_out_t   verdict;
        logic [15:0] received;
        int          hit;
        int          i;
        if (item.cmd == CMD_TABLE_WRITE)
        begin
            // Writes never disturb a frame in progress.
            if (item.entry_index < NODE_COUNT)
                node_table[item.entry_index] = item.entry_eui;
        end
        else
        begin
            if (byte_pos < CHECKED_BYTES)
                crc_acc = crc16_step(crc_acc, item.data_byte);
            if (byte_pos < EUI_BYTES)
                frame_eui = {frame_eui[55:0], item.data_byte};
            else if (byte_pos < CMD_FIRST + CMD_BYTES)
                cmd_vals[byte_pos - CMD_FIRST] = item.data_byte;
            else if (byte_pos == CHECKED_BYTES)
                crc_hi = item.data_byte;

            if (byte_pos + 1 < FRAME_LEN)
            begin
                byte_pos = byte_pos + 1'b1;
            end
            else
            begin
                verdict  = '0;
                received = {crc_hi, item.data_byte};
                if (received != crc_acc)
                begin
                    verdict.status = STATUS_CRC_BAD;
                end
                else
                begin
                    // Search downward so the lowest matching entry is kept.
                    hit = -1;
                    for (i = NODE_COUNT - 1; i >= 0; i--)
                        if (node_table[i] == frame_eui)
                            hit = i;
                    if (hit < 0)
                    begin
                        verdict.status = STATUS_NO_MATCH;
                    end
                    else
                    begin
                        verdict.status        = STATUS_MATCH;
                        verdict.node_index    = hit[3:0];
                        verdict.write_flag    = cmd_vals[0];
                        verdict.unit_state    = cmd_vals[1];
                        verdict.unit_mode     = cmd_vals[2];
                        verdict.fan_level     = cmd_vals[3];
                        verdict.temp_setpoint = cmd_vals[4];
                        verdict.read_flag     = cmd_vals[5];
                    end
                end
                expected_verdicts.push_back(verdict);
                byte_pos = '0;
                crc_acc  = CRC_INIT;
            end
        end
    endtask

    // Compare one result transfer against the oldest predicted verdict.
    task automatic check_verdict(input cfcc_out_t got);
        cfcc_out_t want;
        if (got.status == STATUS_CRC_BAD)
            crc_bad_seen++;
        else if (got.status == STATUS_NO_MATCH)
            no_match_seen++;
        else if (got.status == STATUS_MATCH)
            match_seen++;

        if (expected_verdicts.size() == 0)
        begin
            mismatches++;
            $display("%0t: result transfer with no verdict pending, status %0h",
                     $time, got.status);
        end
        else
        begin
            want = expected_verdicts.pop_front();
            compare_field("status", 8'(want.status), 8'(got.status));
            compare_field("node_index", 8'(want.node_index), 8'(got.node_index));
            compare_field("write_flag", want.write_flag, got.write_flag);
            compare_field("unit_state", want.unit_state, got.unit_state);
            compare_field("unit_mode", want.unit_mode, got.unit_mode);
            compare_field("fan_level", want.fan_level, got.fan_level);
            compare_field("temp_setpoint", want.temp_setpoint, got.temp_setpoint);
            compare_field("read_flag", want.read_flag, got.read_flag);
        end
    endtask

    // Sample both channels at the clock edge; results are checked before the
    // input transfer of the same edge is absorbed.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            byte_pos  = '0;
            crc_acc   = CRC_INIT;
            frame_eui = '0;
            crc_hi    = '0;
            for (int i = 0; i < CMD_BYTES; i++)
                cmd_vals[i] = '0;
            for (int i = 0; i < NODE_COUNT; i++)
                node_table[i] = '0;
            expected_verdicts.delete();
        end
        else
        begin
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
                check_verdict(result_ch.data);
            if (frame_ch.valid === 1'b1 && frame_ch.ready === 1'b1)
                absorb_transfer(frame_ch.data);
        end
        error_count    <= mismatches;
        pending_count  <= expected_verdicts.size();
        crc_bad_count  <= crc_bad_seen;
        no_match_count <= no_match_seen;
        match_count    <= match_seen;
    end

endmodule

// ===== tb/tb.sv =====
// Top of the testbench for command_frame_crc_check_and_match: clock, reset, frame
// and node table stimulus, result-side stalls and the final verdict.
// Depends on cfcc_pkg, the channel interfaces and frame_verdict_checker.
module tb;
    import cfcc_pkg::*;

    localparam int ITEM_TARGET  = 1600;
    localparam int DRAIN_CYCLES = 2 * (NODE_COUNT_DEF + 2) + 16;
    localparam int LONG_HOLD    = 1200;
    // The slowest run is about 1600 transfers, each with the block's byte work and an
    // idle gap, a hundred results behind the table search and stalls, and one hold.
    localparam int LIMIT_CYCLES = 400_000;

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   items_sent;
    int   frame_count;
    int   write_count;
    int   burst_left;
    int   error_count;
    int   pending_count;
    int   crc_bad_count;
    int   no_match_count;
    int   match_count;

    // Shadow of the node table, used to aim frames at stored EUIs.
    logic [63:0] node_euis [NODE_COUNT_DEF];

    cfcc_in_if  frame_ch ();
    cfcc_out_if result_ch ();

    command_frame_crc_check_and_match u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_in   (frame_ch),
        .result_out (result_ch)
    );

    frame_verdict_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .frame_ch       (frame_ch),
        .result_ch      (result_ch),
        .error_count    (error_count),
        .pending_count  (pending_count),
        .crc_bad_count  (crc_bad_count),
        .no_match_count (no_match_count),
        .match_count    (match_count)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: end the run if it goes on far longer than any correct run.
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Result side: runs of random readiness, some with no stalls at all, and
    // one long hold-off so the block backs up into its input.
    initial
    begin : result_stalls
        int ready_pct;
        int run_len;
        int edges;
        bit held;
        edges = 0;
        held  = 1'b0;
        result_ch.ready <= 1'b0;
        forever
        begin
            ready_pct = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(10, 90);
            run_len   = $urandom_range(4, 60);
            repeat (run_len)
            begin
                @(posedge clk);
                edges++;
                result_ch.ready <= ($urandom_range(0, 99) < ready_pct);
            end
            if (!held && edges > 3000)
            begin
                held = 1'b1;
                @(posedge clk);
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                edges += LONG_HOLD + 1;
            end
        end
    end

    // Offer one item and wait for its transfer; idle gaps fall between bursts.
    task automatic send_item(input cfcc_in_t item);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                frame_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        frame_ch.valid <= 1'b1;
        frame_ch.data  <= item;
        do
        begin
            @(posedge clk);
        end
        while (frame_ch.ready !== 1'b1);
        burst_left--;
        items_sent++;
    endtask

    // Write one node table entry; the unused byte field carries noise.
    task automatic write_entry(input logic [3:0] idx, input logic [63:0] eui);
        cfcc_in_t item;
        item.cmd         = CMD_TABLE_WRITE;
        item.data_byte   = 8'($urandom);
        item.entry_index = idx;
        item.entry_eui   = eui;
        node_euis[idx]   = eui;
        write_count++;
        send_item(item);
    endtask

    // EUI for a table write: random, a copy of another entry, zero or all ones.
    function automatic logic [63:0] pick_entry_eui();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return {$urandom, $urandom};
        else if (pick < 7)
            return node_euis[$urandom_range(0, NODE_COUNT_DEF - 1)];
        else if (pick < 8)
            return '0;
        else
            return '1;
    endfunction

    // Build and send one 17-byte frame. A corrupted frame gets a wrong CRC.
    // Table writes may be slipped in at random, and one at a chosen position.
    task automatic send_frame(input logic [63:0] eui, input logic [47:0] values,
                              input bit corrupt, input int stray_pct, input int mid_pos,
                              input logic [3:0] mid_idx, input logic [63:0] mid_eui);
        logic [7:0]  frame_bytes [FRAME_LEN];
        logic [15:0] crc;
        cfcc_in_t    item;
        int          p;
        int          k;
        for (p = 0; p < EUI_BYTES; p++)
            frame_bytes[p] = eui[63 - 8 * p -: 8];
        for (p = 0; p < CMD_BYTES; p++)
            frame_bytes[CMD_FIRST + p] = values[47 - 8 * p -: 8];
        frame_bytes[CHECKED_BYTES - 1] = 8'($urandom);

        crc = CRC_INIT;
        for (p = 0; p < CHECKED_BYTES; p++)
        begin
            crc = crc ^ {frame_bytes[p], 8'h00};
            for (k = 0; k < 8; k++)
                crc = crc[15] ? ({crc[14:0], 1'b0} ^ CRC_POLY) : {crc[14:0], 1'b0};
        end
        if (corrupt)
            crc = crc ^ 16'($urandom_range(1, 65535));
        frame_bytes[CHECKED_BYTES]     = crc[15:8];
        frame_bytes[CHECKED_BYTES + 1] = crc[7:0];

        for (p = 0; p < FRAME_LEN; p++)
        begin
            if (p == mid_pos)
                write_entry(mid_idx, mid_eui);
            if ($urandom_range(0, 99) < stray_pct)
                write_entry(4'($urandom), pick_entry_eui());
            item.cmd         = CMD_FRAME_BYTE;
            item.data_byte   = frame_bytes[p];
            item.entry_index = 4'($urandom);
            item.entry_eui   = {$urandom, $urandom};
            send_item(item);
        end
        frame_count++;
    endtask

    // Reset, directed frames, random frames, then drain and verdict.
    initial
    begin : stimulus
        logic [63:0] eui;
        bit          corrupt;
        int          pick;
        int          stray_pct;
        rst_n       = 1'b0;
        burst_left  = 0;
        items_sent  = 0;
        frame_count = 0;
        write_count = 0;
        for (int i = 0; i < NODE_COUNT_DEF; i++)
            node_euis[i] = '0;
        frame_ch.valid <= 1'b0;
        frame_ch.data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Table entries at both ends, then a good frame for the all-ones EUI
        // with extreme command values; entry 3 takes the same EUI mid-frame,
        // so the lowest matching index must be reported.
        write_entry(4'd15, '1);
        write_entry(4'd0, 64'h0123_4567_89AB_CDEF);
        send_frame('1, 48'hFF00_807F_01FE, 1'b0, 0, 5, 4'd3, '1);

        // Mostly well-formed frames aimed at stored EUIs, plus zero EUIs that
        // hit untouched entries, unknown and near-miss EUIs, and bad CRCs.
        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 99) < 20)
                repeat ($urandom_range(1, 3)) write_entry(4'($urandom), pick_entry_eui());
            pick = $urandom_range(0, 99);
            if (pick < 50)
                eui = node_euis[$urandom_range(0, NODE_COUNT_DEF - 1)];
            else if (pick < 62)
                eui = '0;
            else if (pick < 80)
                eui = {$urandom, $urandom};
            else
                eui = node_euis[$urandom_range(0, NODE_COUNT_DEF - 1)]
                      ^ (64'd1 << $urandom_range(0, 63));
            corrupt   = ($urandom_range(0, 99) < 20);
            stray_pct = ($urandom_range(0, 3) == 0) ? 6 : 0;
            send_frame(eui, {$urandom, 16'($urandom)}, corrupt, stray_pct, -1, 4'd0, '0);
        end
        frame_ch.valid <= 1'b0;

        // Let the checker see the last transfer, wait for every verdict, then
        // leave time for any stray result to show up.
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d transfers: %0d frames and %0d node table writes.",
                 items_sent, frame_count, write_count);
        $display("Checked results: %0d bad CRC, %0d unmatched, %0d matched.",
                 crc_bad_count, no_match_count, match_count);
        if (error_count == 0 && pending_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== command_frame_crc_check_and_match.f =====
design/cfcc_pkg.sv
design/cfcc_if.sv
design/cfcc_ram.sv
design/command_frame_crc_check_and_match.sv
tb/frame_verdict_checker.sv
tb/tb.sv
